// ===== hw/rtl/cdcem_pkg.sv =====
`default_nettype none

package cdcem_pkg;

    localparam int NUM_EVENTS_DEF = 16;

    localparam int DAY_W  = 5;
    localparam int DVAL_W = 6;
    localparam int MON_W  = 4;
    localparam int YEAR_W = 14;
    localparam int WD_W   = 3;
    localparam int IDXIN_W = 4;
    localparam int MASK_W = 16;
    localparam int STAT_W = 2;
    localparam int CMD_W  = 2;

    localparam logic [CMD_W-1:0] CMD_SET   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_WRITE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_STEP  = 2'd2;

    localparam logic [STAT_W-1:0] STAT_OK  = 2'd0;
    localparam logic [STAT_W-1:0] STAT_BAD = 2'd1;
    localparam logic [STAT_W-1:0] STAT_END = 2'd2;

    localparam logic [DVAL_W-1:0] DAY_ANY  = 6'h00;
    localparam logic [DVAL_W-1:0] DAY_LAST = 6'h3F;

    localparam logic [YEAR_W-1:0] YEAR_MIN = 14'd1754;
    localparam logic [YEAR_W-1:0] YEAR_MAX = 14'd9999;

    localparam logic [WD_W-1:0] WD_TUESDAY = 3'd2;
    localparam logic [WD_W-1:0] WD_SUNDAY  = 3'd7;

    typedef struct packed {
        logic [DVAL_W-1:0] day;
        logic [MON_W-1:0]  month;
        logic [YEAR_W-1:0] year;
        logic [WD_W-1:0]   weekday;
    } ev_entry_t;

    typedef struct packed {
        logic            done;
        logic            leap;
        logic [WD_W-1:0] weekday;
    } calc_res_t;

    // floor(23 * m / 9) for the weekday formula
    function automatic logic [4:0] month_term(input logic [MON_W-1:0] m);
        logic [4:0] t;
        unique case (m)
            4'd1:    t = 5'd2;
            4'd2:    t = 5'd5;
            4'd3:    t = 5'd7;
            4'd4:    t = 5'd10;
            4'd5:    t = 5'd12;
            4'd6:    t = 5'd15;
            4'd7:    t = 5'd17;
            4'd8:    t = 5'd20;
            4'd9:    t = 5'd23;
            4'd10:   t = 5'd25;
            4'd11:   t = 5'd28;
            4'd12:   t = 5'd30;
            default: t = 5'd0;
        endcase
        return t;
    endfunction

    function automatic logic [DAY_W-1:0] month_len(input logic [MON_W-1:0] m,
                                                   input logic leap);
        logic [DAY_W-1:0] len;
        unique case (m)
            4'd2:                   len = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
            default:                len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/cdcem_event_mem.sv =====
`default_nettype none

module cdcem_event_mem #(
    parameter int NUM_EVENTS = cdcem_pkg::NUM_EVENTS_DEF,
    parameter int IDX_W      = (NUM_EVENTS > 1) ? $clog2(NUM_EVENTS) : 1
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  wr_en,
    input  wire logic [IDX_W-1:0]      wr_addr,
    input  wire logic                  wr_active,
    input  wire cdcem_pkg::ev_entry_t  wr_data,
    input  wire logic                  rd_en,
    input  wire logic [IDX_W-1:0]      rd_addr,
    output logic                       rd_active,
    output cdcem_pkg::ev_entry_t       rd_data
);
    import cdcem_pkg::*;

    ev_entry_t              mem [NUM_EVENTS];
    logic [NUM_EVENTS-1:0]  active_reg;
    ev_entry_t              rd_data_reg;
    logic                   rd_active_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // active flags reset to cleared; the entries themselves need no reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg    <= '0;
            rd_active_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                active_reg[wr_addr] <= wr_active;
            end
            if (rd_en) begin
                rd_active_reg <= active_reg[rd_addr];
            end
        end
    end

    assign rd_data   = rd_data_reg;
    assign rd_active = rd_active_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/cdcem_date_calc.sv =====
`default_nettype none

// Leap flag and weekday of a date; done marks when they are ready after start.
module cdcem_date_calc (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        start,
    input  wire logic [cdcem_pkg::DAY_W-1:0]  day,
    input  wire logic [cdcem_pkg::MON_W-1:0]  month,
    input  wire logic [cdcem_pkg::YEAR_W-1:0] year,
    output cdcem_pkg::calc_res_t             res
);
    import cdcem_pkg::*;

    localparam logic [22:0] RECIP_25 = 23'd1311;    // 2^15 / 25, exact below 2500
    localparam logic [30:0] RECIP_7  = 31'd37450;   // 2^18 / 7, exact below 16384

    logic [YEAR_W-1:0] y_reg;
    logic [YEAR_W-1:0] yy_reg;
    logic [14:0]       dd_reg;
    logic [4:0]        mt_reg;

    logic [22:0] p_y100_reg, p_y400_reg, p_yy100_reg, p_yy400_reg;
    logic [YEAR_W-1:0] rem100_reg, rem400_reg;
    logic [14:0] sum_reg;
    logic [30:0] p7_reg;
    logic        leap_reg;
    logic [WD_W-1:0] wd_reg;

    logic [2:0] cnt_reg;
    logic       done_reg;

    logic [7:0]  q_y100, q_yy100;
    logic [5:0]  q_y400, q_yy400;
    logic [12:0] q7;
    logic [14:0] rem7;
    logic        early;

    assign early   = (month < 4'd3);
    assign q_y100  = p_y100_reg[22:15];
    assign q_y400  = p_y400_reg[20:15];
    assign q_yy100 = p_yy100_reg[22:15];
    assign q_yy400 = p_yy400_reg[20:15];
    assign q7      = p7_reg[30:18];
    assign rem7    = sum_reg - 15'({2'b0, q7} * 15'd7);

    always_ff @(posedge aclk) begin
        if (start) begin
            y_reg  <= year;
            yy_reg <= early ? (year - 14'd1) : year;
            dd_reg <= early ? (15'(day) + 15'(year)) : (15'(day) + 15'(year) - 15'd2);
            mt_reg <= month_term(month);
        end
        p_y100_reg  <= 23'(y_reg[13:2])  * RECIP_25;
        p_y400_reg  <= 23'(y_reg[13:4])  * RECIP_25;
        p_yy100_reg <= 23'(yy_reg[13:2]) * RECIP_25;
        p_yy400_reg <= 23'(yy_reg[13:4]) * RECIP_25;
        rem100_reg  <= y_reg - 14'({6'b0, q_y100} * 14'd100);
        rem400_reg  <= y_reg - 14'({8'b0, q_y400} * 14'd400);
        sum_reg     <= 15'(mt_reg) + dd_reg + 15'd4 + 15'(yy_reg[13:2])
                       - 15'(q_yy100) + 15'(q_yy400);
        p7_reg      <= 31'(sum_reg) * RECIP_7;
        leap_reg    <= (y_reg[1:0] == 2'b00) && ((rem100_reg != '0) || (rem400_reg == '0));
        wd_reg      <= (rem7[2:0] == 3'd0) ? WD_SUNDAY : rem7[2:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= (cnt_reg == 3'd1);
            if (start) begin
                cnt_reg <= 3'd4;
            end else if (cnt_reg != 3'd0) begin
                cnt_reg <= cnt_reg - 3'd1;
            end
        end
    end

    assign res.done    = done_reg;
    assign res.leap    = leap_reg;
    assign res.weekday = wd_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/calendar_date_counter_event_match_unit.sv =====
`default_nettype none

// Channel   Direction  Ports
// s_        in         s_valid/s_ready, command, day/month/year/weekday values, entry
// m_        out        m_valid/m_ready, date, weekday, match_mask, status
//
// Set date starts the weekday/leap unit and loads its result when that unit signals done;
// write entry updates the table as the item is taken. Report-and-advance scans the event
// table, one read per cycle; a year rollover then waits for the new year's leap flag.
// Reset is synchronous and brings the date to 1.1.1754, a Tuesday, all events off.
// A new item is taken while the previous result still waits on m_ready.
module calendar_date_counter_event_match_unit #(
    parameter int NUM_EVENTS = cdcem_pkg::NUM_EVENTS_DEF
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic [cdcem_pkg::CMD_W-1:0]          s_command,
    input  wire logic signed [cdcem_pkg::DVAL_W-1:0]  s_day_value,
    input  wire logic [cdcem_pkg::MON_W-1:0]          s_month_value,
    input  wire logic [cdcem_pkg::YEAR_W-1:0]         s_year_value,
    input  wire logic [cdcem_pkg::WD_W-1:0]           s_weekday_value,
    input  wire logic [cdcem_pkg::IDXIN_W-1:0]        s_entry_index,
    input  wire logic                                s_entry_enable,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic [cdcem_pkg::DAY_W-1:0]               m_out_day,
    output logic [cdcem_pkg::MON_W-1:0]               m_out_month,
    output logic [cdcem_pkg::YEAR_W-1:0]              m_out_year,
    output logic [cdcem_pkg::WD_W-1:0]                m_out_weekday,
    output logic [cdcem_pkg::MASK_W-1:0]              m_match_mask,
    output logic [cdcem_pkg::STAT_W-1:0]              m_status
);
    import cdcem_pkg::*;

    localparam int IDX_W = (NUM_EVENTS > 1) ? $clog2(NUM_EVENTS) : 1;
    localparam int CNT_W = $clog2(NUM_EVENTS + 1);
    localparam logic [CNT_W-1:0] CNT_END  = CNT_W'(NUM_EVENTS);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(NUM_EVENTS - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SET,
        ST_SCAN,
        ST_LEAP,
        ST_EMIT
    } state_t;

    state_t state_reg;

    logic [DAY_W-1:0]  cur_day_reg;
    logic [MON_W-1:0]  cur_month_reg;
    logic [YEAR_W-1:0] cur_year_reg;
    logic [WD_W-1:0]   cur_wd_reg;
    logic              cur_leap_reg;

    logic [DVAL_W-1:0] set_day_reg;
    logic [MON_W-1:0]  calc_month_reg;
    logic [YEAR_W-1:0] calc_year_reg;
    logic              calc_start_reg;

    logic [CNT_W-1:0]  rd_cnt_reg;
    logic              chk_valid_reg;
    logic [IDX_W-1:0]  chk_idx_reg;
    logic              last_reg;
    logic [MASK_W-1:0] mask_reg;

    logic [DAY_W-1:0]  res_day_reg;
    logic [MON_W-1:0]  res_month_reg;
    logic [YEAR_W-1:0] res_year_reg;
    logic [WD_W-1:0]   res_wd_reg;
    logic [MASK_W-1:0] res_mask_reg;
    logic [STAT_W-1:0] res_status_reg;

    logic              m_valid_reg;
    logic [DAY_W-1:0]  m_day_reg;
    logic [MON_W-1:0]  m_month_reg;
    logic [YEAR_W-1:0] m_year_reg;
    logic [WD_W-1:0]   m_wd_reg;
    logic [MASK_W-1:0] m_mask_reg;
    logic [STAT_W-1:0] m_status_reg;

    calc_res_t  calc_res;
    ev_entry_t  wr_entry;
    ev_entry_t  rd_entry;
    logic       rd_active;
    logic       wr_en;
    logic       rd_en;
    logic       accept;
    logic       hit;
    logic       set_ok;
    logic       end_of_range;
    logic       new_year;
    logic       calc_start_next;
    logic [MASK_W-1:0] mask_next;

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;

    assign wr_en = accept && (s_command == CMD_WRITE)
                   && (32'(s_entry_index) < 32'(NUM_EVENTS));
    assign wr_entry.day     = s_day_value;
    assign wr_entry.month   = s_month_value;
    assign wr_entry.year    = s_year_value;
    assign wr_entry.weekday = s_weekday_value;

    assign rd_en = (state_reg == ST_SCAN) && (rd_cnt_reg < CNT_END);

    cdcem_event_mem #(
        .NUM_EVENTS (NUM_EVENTS),
        .IDX_W      (IDX_W)
    ) u_mem (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .wr_en     (wr_en),
        .wr_addr   (IDX_W'(s_entry_index)),
        .wr_active (s_entry_enable),
        .wr_data   (wr_entry),
        .rd_en     (rd_en),
        .rd_addr   (rd_cnt_reg[IDX_W-1:0]),
        .rd_active (rd_active),
        .rd_data   (rd_entry)
    );

    cdcem_date_calc u_calc (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (calc_start_reg),
        .day     (set_day_reg[DAY_W-1:0]),
        .month   (calc_month_reg),
        .year    (calc_year_reg),
        .res     (calc_res)
    );

    always_comb begin
        hit = rd_active
              && ((rd_entry.year == '0) || (rd_entry.year == cur_year_reg))
              && ((rd_entry.month == '0) || (rd_entry.month == cur_month_reg))
              && ((rd_entry.weekday == '0) || (rd_entry.weekday == cur_wd_reg))
              && ((rd_entry.day == DAY_ANY) || (rd_entry.day == {1'b0, cur_day_reg})
                  || ((rd_entry.day == DAY_LAST) && last_reg));
        // slots above the mask width shift out
        mask_next = mask_reg | (hit ? (MASK_W'(1) << chk_idx_reg) : '0);
    end

    assign set_ok = (calc_month_reg >= 4'd1) && (calc_month_reg <= 4'd12)
                    && (calc_year_reg >= YEAR_MIN) && (calc_year_reg <= YEAR_MAX)
                    && !set_day_reg[DVAL_W-1] && (set_day_reg != '0)
                    && (set_day_reg[DAY_W-1:0] <= month_len(calc_month_reg, calc_res.leap));

    assign end_of_range = (cur_day_reg == 5'd31) && (cur_month_reg == 4'd12)
                          && (cur_year_reg >= YEAR_MAX);

    // last slot checked on a Dec 31 below the end of the range
    assign new_year = (state_reg == ST_SCAN) && chk_valid_reg && (chk_idx_reg == IDX_LAST)
                      && !end_of_range && (cur_month_reg >= 4'd12)
                      && (cur_day_reg >= month_len(cur_month_reg, cur_leap_reg));

    assign calc_start_next = (accept && (s_command == CMD_SET)) || new_year;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            cur_day_reg    <= 5'd1;
            cur_month_reg  <= 4'd1;
            cur_year_reg   <= YEAR_MIN;
            cur_wd_reg     <= WD_TUESDAY;
            cur_leap_reg   <= 1'b0;
            calc_start_reg <= 1'b0;
            chk_valid_reg  <= 1'b0;
            rd_cnt_reg     <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            calc_start_reg <= calc_start_next;
            chk_valid_reg  <= rd_en;
            if ((state_reg == ST_EMIT) && (!m_valid_reg || m_ready)) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        set_day_reg    <= s_day_value;
                        calc_month_reg <= s_month_value;
                        calc_year_reg  <= s_year_value;
                        res_day_reg    <= cur_day_reg;
                        res_month_reg  <= cur_month_reg;
                        res_year_reg   <= cur_year_reg;
                        res_wd_reg     <= cur_wd_reg;
                        res_mask_reg   <= '0;
                        res_status_reg <= STAT_OK;
                        unique case (s_command)
                            CMD_SET: begin
                                state_reg <= ST_SET;
                            end
                            CMD_WRITE: begin
                                state_reg <= ST_EMIT;
                            end
                            CMD_STEP: begin
                                last_reg   <= (cur_day_reg ==
                                               month_len(cur_month_reg, cur_leap_reg));
                                rd_cnt_reg <= '0;
                                mask_reg   <= '0;
                                state_reg  <= ST_SCAN;
                            end
                            default: begin
                                // unused command: drop the item
                                state_reg <= ST_IDLE;
                            end
                        endcase
                    end
                end

                ST_SET: begin
                    if (calc_res.done) begin
                        if (set_ok) begin
                            cur_day_reg   <= set_day_reg[DAY_W-1:0];
                            cur_month_reg <= calc_month_reg;
                            cur_year_reg  <= calc_year_reg;
                            cur_wd_reg    <= calc_res.weekday;
                            cur_leap_reg  <= calc_res.leap;
                            res_day_reg   <= set_day_reg[DAY_W-1:0];
                            res_month_reg <= calc_month_reg;
                            res_year_reg  <= calc_year_reg;
                            res_wd_reg    <= calc_res.weekday;
                        end else begin
                            res_status_reg <= STAT_BAD;
                        end
                        state_reg <= ST_EMIT;
                    end
                end

                ST_SCAN: begin
                    if (rd_en) begin
                        chk_idx_reg <= rd_cnt_reg[IDX_W-1:0];
                        rd_cnt_reg  <= rd_cnt_reg + CNT_W'(1);
                    end
                    if (chk_valid_reg) begin
                        mask_reg <= mask_next;
                        if (chk_idx_reg == IDX_LAST) begin
                            res_mask_reg <= mask_next;
                            // new year: fetch its leap flag
                            state_reg    <= new_year ? ST_LEAP : ST_EMIT;
                            if (end_of_range) begin
                                res_status_reg <= STAT_END;
                            end else begin
                                cur_wd_reg <= (cur_wd_reg >= WD_SUNDAY) ? 3'd1
                                                                       : cur_wd_reg + 3'd1;
                                if (cur_day_reg >= month_len(cur_month_reg, cur_leap_reg)) begin
                                    cur_day_reg <= 5'd1;
                                    if (cur_month_reg >= 4'd12) begin
                                        cur_month_reg  <= 4'd1;
                                        cur_year_reg   <= cur_year_reg + 14'd1;
                                        calc_month_reg <= 4'd1;
                                        calc_year_reg  <= cur_year_reg + 14'd1;
                                    end else begin
                                        cur_month_reg <= cur_month_reg + 4'd1;
                                    end
                                end else begin
                                    cur_day_reg <= cur_day_reg + 5'd1;
                                end
                            end
                        end
                    end
                end

                ST_LEAP: begin
                    if (calc_res.done) begin
                        cur_leap_reg <= calc_res.leap;
                        state_reg    <= ST_EMIT;
                    end
                end

                ST_EMIT: begin
                    if (!m_valid_reg || m_ready) begin
                        m_day_reg    <= res_day_reg;
                        m_month_reg  <= res_month_reg;
                        m_year_reg   <= res_year_reg;
                        m_wd_reg     <= res_wd_reg;
                        m_mask_reg   <= res_mask_reg;
                        m_status_reg <= res_status_reg;
                        state_reg    <= ST_IDLE;
                    end
                end

                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_out_day     = m_day_reg;
    assign m_out_month   = m_month_reg;
    assign m_out_year    = m_year_reg;
    assign m_out_weekday = m_wd_reg;
    assign m_match_mask  = m_mask_reg;
    assign m_status      = m_status_reg;

endmodule

`default_nettype wire
